// File: rtl/assert_macros.svh
// assertion macros shared by the byte ring fifo modules
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge out of reset
`define BRF_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// a condition that implies another in the next cycle
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/brf_pkg.sv
// types, codes and sizes for the byte ring fifo with peek and drop
// no dependencies
`timescale 1ns / 1ps

package brf_pkg;

   localparam int STORE_DEPTH = 2048;
   localparam int IDX_W       = 11;
   localparam int MAX_BURST   = 64;
   localparam int CNT_W       = $clog2(MAX_BURST + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 4;
   localparam logic [IDX_W-1:0] CAPACITY_RESET = 11'd1024;

   typedef enum logic [2:0] {
      CMD_WRITE   = 3'd0,
      CMD_READ    = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_DROP    = 3'd3,
      CMD_DISCARD = 3'd4,
      CMD_STATUS  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_NO_DATA  = 2'd2,
      ST_BAD_LEN  = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [7:0]        data_in;
      logic [IDX_W-1:0]  length;
      logic [IDX_W-1:0]  offset;
      logic              burst_last;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        data_out;
      logic [IDX_W-1:0]  used_count;
      logic [IDX_W-1:0]  free_count;
      logic              last;
   } rsp_type;

   // work for the back end: count zero means one result without data
   typedef struct packed {
      status_type        status;
      logic [CNT_W-1:0]  count;
      logic [IDX_W-1:0]  pos;
      logic [IDX_W-1:0]  used_count;
      logic [IDX_W-1:0]  free_count;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [7:0]        data;
   } mem_wr_type;

endpackage

// File: rtl/brf_job_queue.sv
// short job queue between the front end and the back end
// depends on brf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brf_job_queue
   import brf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   input  logic    pop,
   output job_type job_out,
   output logic    full,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_QW-1:0]   count_ff;

   assign full    = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign job_out = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `BRF_ASSERT(a_queue_no_overflow, !(push && full && !pop), "job queue overflow")
   `BRF_ASSERT(a_queue_no_underflow, !(pop && empty), "job queue underflow")
   `BRF_ASSERT_NEXT(a_queue_push_lands, push && !pop, !empty, "pushed job lost")

endmodule

// File: rtl/brf_front.sv
// front end: takes items and config writes, keeps head, tail and fill state,
// writes bytes and posts result jobs; depends on brf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brf_front
   import brf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_payload,
   output logic             req_stall,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_wdata,
   input  logic             queue_full,
   input  logic             back_idle,
   output logic             job_push,
   output job_type          job,
   output mem_wr_type       mem_wr,
   output logic [IDX_W-1:0] capacity
);

   logic [IDX_W-1:0] capacity_ff, capacity_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] used_ff, used_in;
   logic             burst_ff, burst_in;
   logic             rejected_ff, rejected_in;

   logic             accept;
   logic             csr_write;
   logic [IDX_W-1:0] free_now;
   logic [IDX_W:0]   slots;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] step,
                                                 input logic [IDX_W:0]   ring);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, step};
      if (sum >= ring) begin
         sum = sum - ring;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign capacity  = capacity_ff;
   assign free_now  = capacity_ff - used_ff;
   assign slots     = {1'b0, capacity_ff} + 1'b1;

   // items wait out a capacity write; writes wait until every posted job is issued
   assign req_stall = queue_full || csr_valid ||
                      (req_payload.cmd == CMD_WRITE && !back_idle);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      logic             first;
      logic             rej;
      logic [IDX_W-1:0] offs_eff;
      logic [IDX_W:0]   span;

      capacity_in = capacity_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      used_in     = used_ff;
      burst_in    = burst_ff;
      rejected_in = rejected_ff;
      job_push    = 1'b0;
      job         = '0;
      job.status  = ST_OK;
      mem_wr      = '0;
      first       = !burst_ff;
      rej         = 1'b0;
      offs_eff    = (req_payload.cmd == CMD_PEEK) ? req_payload.offset : '0;
      span        = {1'b0, offs_eff} + {1'b0, req_payload.length};

      if (csr_write) begin
         capacity_in = csr_wdata;
         head_in     = '0;
         tail_in     = '0;
         used_in     = '0;
      end else if (accept) begin
         if (req_payload.cmd != CMD_WRITE) begin
            burst_in    = 1'b0;
            rejected_in = 1'b0;
         end
         unique case (req_payload.cmd)
            CMD_WRITE: begin
               if (first) begin
                  rej = (req_payload.length == '0) || (req_payload.length > free_now);
                  if (req_payload.length != '0 && req_payload.length > free_now) begin
                     job_push   = 1'b1;
                     job.status = ST_NO_SPACE;
                  end
               end else begin
                  rej = rejected_ff;
               end
               if (!rej && used_ff < capacity_ff) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = tail_ff;
                  mem_wr.data = req_payload.data_in;
                  tail_in     = (tail_ff == capacity_ff) ? '0 : tail_ff + 1'b1;
                  used_in     = used_ff + 1'b1;
               end
               burst_in    = !req_payload.burst_last;
               rejected_in = !req_payload.burst_last && rej;
            end
            CMD_READ, CMD_PEEK: begin
               job_push = 1'b1;
               if (req_payload.length == '0) begin
                  job.status = ST_OK;
               end else if (req_payload.length > IDX_W'(MAX_BURST)) begin
                  job.status = ST_BAD_LEN;
               end else if ({1'b0, used_ff} < span) begin
                  job.status = ST_NO_DATA;
               end else begin
                  job.status = ST_OK;
                  job.count  = req_payload.length[CNT_W-1:0];
                  job.pos    = ring_add(head_ff, offs_eff, slots);
                  if (req_payload.cmd == CMD_READ) begin
                     head_in = ring_add(head_ff, req_payload.length, slots);
                     used_in = used_ff - req_payload.length;
                  end
               end
            end
            CMD_DROP: begin
               job_push = 1'b1;
               if (req_payload.length > used_ff) begin
                  job.status = ST_NO_DATA;
               end else begin
                  head_in = ring_add(head_ff, req_payload.length, slots);
                  used_in = used_ff - req_payload.length;
               end
            end
            CMD_DISCARD: begin
               job_push = 1'b1;
               head_in  = '0;
               tail_in  = '0;
               used_in  = '0;
            end
            default: begin
               job_push = 1'b1;
            end
         endcase
      end

      job.used_count = used_in;
      job.free_count = capacity_in - used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         used_ff     <= '0;
         burst_ff    <= 1'b0;
         rejected_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         used_ff     <= used_in;
         burst_ff    <= burst_in;
         rejected_ff <= rejected_in;
      end
   end

   `BRF_ASSERT(a_used_within_capacity, used_ff <= capacity_ff, "fill above capacity")
   `BRF_ASSERT(a_write_only_when_idle, !mem_wr.en || back_idle, "byte written during read")
   `BRF_ASSERT_NEXT(a_store_counts, mem_wr.en, used_ff == $past(used_ff) + 1'b1,
                    "stored byte not counted")

endmodule

// File: rtl/brf_back.sv
// back end: holds the byte store, walks each job and emits its results
// through a small output queue; depends on brf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brf_back
   import brf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] capacity,
   input  mem_wr_type       mem_wr,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   output logic             busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload
);

   localparam int OPTR_W = $clog2(OUT_DEPTH);
   localparam int OCNT_W = $clog2(OUT_DEPTH + 2);

   logic [7:0]        store_mem [STORE_DEPTH];

   logic              busy_ff;
   job_type           job_ff;
   logic [CNT_W-1:0]  remain_ff;
   logic              is_data_ff;

   logic              pend_ff;
   rsp_type           pend_meta_ff;
   logic              pend_data_ff;
   logic [7:0]        rd_data_ff;

   rsp_type           out_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] out_wr_ff;
   logic [OPTR_W-1:0] out_rd_ff;
   logic [OCNT_W-1:0] out_count_ff;

   logic              credit;
   logic              issue;
   logic              issue_last;
   logic              out_pop;
   rsp_type           out_push_data;

   assign credit     = (out_count_ff + OCNT_W'(pend_ff)) < OCNT_W'(OUT_DEPTH);
   assign issue      = busy_ff && credit;
   assign issue_last = issue && (remain_ff == CNT_W'(1));
   assign job_pop    = !busy_ff && job_valid;
   assign busy       = busy_ff;
   assign out_pop    = rsp_valid && !rsp_stall;
   assign rsp_valid  = (out_count_ff != '0);
   assign rsp_payload = out_ff[out_rd_ff];

   always_comb begin
      out_push_data          = pend_meta_ff;
      out_push_data.data_out = pend_data_ff ? rd_data_ff : 8'd0;
   end

   // byte store with registered read
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         store_mem[mem_wr.addr] <= mem_wr.data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[job_ff.pos];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pend_meta_ff.status     <= job_ff.status;
         pend_meta_ff.data_out   <= 8'd0;
         pend_meta_ff.used_count <= job_ff.used_count;
         pend_meta_ff.free_count <= job_ff.free_count;
         pend_meta_ff.last       <= (remain_ff == CNT_W'(1));
         pend_data_ff            <= is_data_ff;
      end
      if (pend_ff) begin
         out_ff[out_wr_ff] <= out_push_data;
      end
      if (job_pop) begin
         job_ff     <= job;
         remain_ff  <= (job.count == '0) ? CNT_W'(1) : job.count;
         is_data_ff <= (job.count != '0);
      end else if (issue) begin
         remain_ff  <= remain_ff - 1'b1;
         job_ff.pos <= (job_ff.pos == capacity) ? '0 : job_ff.pos + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (job_pop) begin
            busy_ff <= 1'b1;
         end else if (issue_last) begin
            busy_ff <= 1'b0;
         end
         pend_ff <= issue;
         if (pend_ff) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
         unique case ({pend_ff, out_pop})
            2'b10:   out_count_ff <= out_count_ff + 1'b1;
            2'b01:   out_count_ff <= out_count_ff - 1'b1;
            default: out_count_ff <= out_count_ff;
         endcase
      end
   end

   `BRF_ASSERT(a_out_room, (out_count_ff + OCNT_W'(pend_ff)) <= OCNT_W'(OUT_DEPTH),
               "output queue overrun")
   `BRF_ASSERT_NEXT(a_last_ends_job, issue_last, !busy_ff, "job still busy after last")
   `BRF_ASSERT_NEXT(a_issue_lands, issue, pend_ff, "issued result lost")

endmodule

// File: rtl/byte_ring_fifo_peek_drop.sv
// top level of the byte ring fifo with peek and drop
// depends on brf_pkg, brf_front, brf_job_queue and brf_back
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_type (cmd, data_in, length, offset, burst_last)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type (status, data_out, used/free, last)
//  csr     | in        | csr_valid/csr_ready | capacity, 11 bits
//
//  a write byte is stored in the same cycle it is taken; write bytes
//  run one per cycle, but wait while any posted job is queued or not yet issued
//  every other command posts one job; its first result moves through the job queue, job
//  register and pending stage to the output queue; a read or peek of n bytes then gives
//  one result per cycle while the output has room, set by the single read port of the store
//  synchronous reset restores capacity 1024 and an empty fifo; the store
//  itself is not cleared and needs no sweep
//  a stalled output holds up to four results, then the job queue of four
//  fills and req_stall rises; items also wait in a cycle with csr_valid high

module byte_ring_fifo_peek_drop
   import brf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_wdata
);

   // front to queue
   logic             job_push;
   job_type          job_in;
   logic             queue_full;
   logic             queue_empty;

   // queue to back
   job_type          job_out;
   logic             job_pop;
   logic             back_busy;

   // shared state
   mem_wr_type       mem_wr;
   logic [IDX_W-1:0] capacity;
   logic             back_idle;

   // the back end is idle for writes once every job has been issued
   assign back_idle = queue_empty && !back_busy;

   brf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .back_idle   (back_idle),
      .job_push    (job_push),
      .job         (job_in),
      .mem_wr      (mem_wr),
      .capacity    (capacity)
   );

   brf_job_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (job_in),
      .pop     (job_pop),
      .job_out (job_out),
      .full    (queue_full),
      .empty   (queue_empty)
   );

   brf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity),
      .mem_wr      (mem_wr),
      .job_valid   (!queue_empty),
      .job         (job_out),
      .job_pop     (job_pop),
      .busy        (back_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
